// ===== rtl/core/rtt_congestion_detector_macros.svh =====
// assertion helpers for the rtt congestion detector
// define NO_ASSERTIONS to compile them out
`ifndef RTT_CONGESTION_DETECTOR_MACROS_SVH
`define RTT_CONGESTION_DETECTOR_MACROS_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, disabled in reset
`define RCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// next-cycle implication, disabled in reset
`define RCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define RCD_ASSERT_IMP(lbl, clk, rst_n, ante, cons)
`define RCD_ASSERT_NXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/core/rcd_pkg.sv =====
`default_nettype none

package rcd_pkg;

  // field widths
  localparam int unsigned MEAN_W     = 24;
  localparam int unsigned TIME_W     = 48;
  localparam int unsigned PCT_W      = 7;
  localparam int unsigned RECOVERY_W = 26;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned TENS_W     = 4;

  // configuration port
  localparam int unsigned CFG_IDX_W  = 4;
  localparam int unsigned CFG_DATA_W = 26;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_THRESHOLD = 4'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_IDX_RECOVERY  = 4'd1;

  localparam logic [PCT_W-1:0]      THRESHOLD_RST = 7'd90;
  localparam logic [RECOVERY_W-1:0] RECOVERY_RST  = 26'd5000000;

  // recent-signal window
  localparam logic [TIME_W-1:0] RECENT_US = 48'd1000000;

  // congestion status codes
  localparam logic [STATUS_W-1:0] ST_NONE     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BUILDING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_IMMINENT = 2'd2;

  localparam logic [PCT_W-1:0] PCT_MAX      = 7'd100;
  localparam logic [PCT_W-1:0] BUILDING_MIN = 7'd50;

  typedef enum logic [1:0] {
    TREND_UNDEF  = 2'd0,
    TREND_INC    = 2'd1,
    TREND_STABLE = 2'd2,
    TREND_DEC    = 2'd3
  } trend_e;

  typedef struct packed {
    logic [MEAN_W-1:0] rtt_mean_us;
    logic [MEAN_W-1:0] rtt_spread_us;
    logic [1:0]        trend_code;
    logic              spike_seen;
    logic [TIME_W-1:0] now_us;
  } rtt_sample_t;

  typedef struct packed {
    logic [STATUS_W-1:0] congestion_status;
    logic [PCT_W-1:0]    confidence_pct;
  } rcd_result_t;

  typedef struct packed {
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;
  } cfg_write_t;

  // per-sample window slot: occupied, and step into it was a decrease
  typedef struct packed {
    logic filled;
    logic brk;
  } rcd_slot_t;

endpackage

`default_nettype wire

// ===== rtl/core/rcd_stream_if.sv =====
`default_nettype none

interface rcd_stream_if #(
  parameter type payload_t = logic
) ();
  logic     valid;
  logic     ready;
  payload_t payload;

  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== rtl/core/rcd_cell.sv =====
`default_nettype none

module rcd_cell
  import rcd_pkg::*;
(
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            shift_i,
  input  wire rcd_slot_t slot_i,
  output rcd_slot_t      slot_o,
  output rcd_slot_t      slot_nxt_o
);

  rcd_slot_t slot_d, slot_q;

  // take the neighbor's slot on every new sample
  always_comb begin
    slot_d = shift_i ? slot_i : slot_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      slot_q <= '0;
    end else begin
      slot_q <= slot_d;
    end
  end

  assign slot_o     = slot_q;
  assign slot_nxt_o = slot_d;

endmodule

`default_nettype wire

// ===== rtl/core/rcd_out_buf.sv =====
`default_nettype none

module rcd_out_buf
  import rcd_pkg::*;
(
  input  wire              clk_i,
  input  wire              rst_ni,
  input  wire              push_i,
  input  wire rcd_result_t data_i,
  output logic             space_o,
  output logic             valid_o,
  input  wire              ready_i,
  output rcd_result_t      data_o
);

  rcd_result_t mem_q [2];
  logic        wr_ptr_q, rd_ptr_q;
  logic [1:0]  cnt_d, cnt_q;
  logic        pop;

  assign pop     = valid_o && ready_i;
  assign valid_o = (cnt_q != 2'd0);
  assign space_o = (cnt_q != 2'd2);
  assign data_o  = mem_q[rd_ptr_q];

  // occupancy
  always_comb begin
    cnt_d = cnt_q;
    case ({push_i, pop})
      2'b10:   cnt_d = cnt_q + 2'd1;
      2'b01:   cnt_d = cnt_q - 2'd1;
      default: cnt_d = cnt_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= 2'd0;
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
    end else begin
      cnt_q <= cnt_d;
      if (push_i) begin
        wr_ptr_q <= ~wr_ptr_q;
      end
      if (pop) begin
        rd_ptr_q <= ~rd_ptr_q;
      end
    end
  end

  // result storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= data_i;
    end
  end

endmodule

`default_nettype wire

// ===== rtl/core/rtt_congestion_detector.sv =====
// channel   dir  modport  payload
// rtt_i     in   sink     rtt_sample_t (mean, spread, trend, spike, time)
// res_o     out  source   rcd_result_t (status, confidence)
// cfg_i     in   sink     cfg_write_t (index, data), always ready
//
// one sample per cycle while the result buffer has space; its result is pushed into that buffer on acceptance
// the status and signal-time registers take their new values in the same cycle that the sample is accepted
// a two-entry result buffer keeps intake going while one result waits on the output;
// rtt_i.ready drops only when both entries wait
// reset clears the window cells, status and config to their defaults
`default_nettype none

`include "rtt_congestion_detector_macros.svh"

module rtt_congestion_detector
  import rcd_pkg::*;
#(
  parameter int unsigned WINDOW = 16
) (
  input wire            clk_i,
  input wire            rst_ni,
  rcd_stream_if.sink    rtt_i,
  rcd_stream_if.source  res_o,
  rcd_stream_if.sink    cfg_i
);

  rtt_sample_t smp;
  logic        accept;
  logic        space;

  // configuration registers
  logic [PCT_W-1:0]      thresh_d, thresh_q;
  logic [RECOVERY_W-1:0] recovery_d, recovery_q;

  // detector state
  logic [MEAN_W-1:0]   prev_mean_d, prev_mean_q;
  logic [STATUS_W-1:0] status_d, status_q;
  logic [TIME_W-1:0]   sig_time_d, sig_time_q;
  logic                seen_d, seen_q;

  rcd_slot_t slot_q   [WINDOW];
  rcd_slot_t slot_nxt [WINDOW];
  rcd_slot_t slot_new;
  logic      sustained;

  logic [TIME_W-1:0]   elapsed;
  logic                recent;
  logic [MEAN_W+2:0]   spread_x5;
  logic [TENS_W-1:0]   tens;
  logic [7:0]          scaled;
  logic [PCT_W-1:0]    score;
  logic [STATUS_W-1:0] status_nxt;
  rcd_result_t         result;

  assign smp         = rtt_i.payload;
  assign rtt_i.ready = space;
  assign accept      = rtt_i.valid && space;
  assign cfg_i.ready = 1'b1;

  // register writes
  always_comb begin
    thresh_d   = thresh_q;
    recovery_d = recovery_q;
    if (cfg_i.valid) begin
      case (cfg_i.payload.index)
        CFG_IDX_THRESHOLD: thresh_d   = cfg_i.payload.data[PCT_W-1:0];
        CFG_IDX_RECOVERY:  recovery_d = cfg_i.payload.data[RECOVERY_W-1:0];
        default:           thresh_d   = thresh_q;
      endcase
    end
  end

  // window: newest slot enters cell 0 and ripples down the row
  assign slot_new = '{filled: 1'b1,
                      brk: slot_q[0].filled && (smp.rtt_mean_us < prev_mean_q)};

  for (genvar i = 0; i < WINDOW; i++) begin : g_cell
    rcd_cell u_cell (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .shift_i    (accept),
      .slot_i     ((i == 0) ? slot_new : slot_q[(i == 0) ? 0 : i-1]),
      .slot_o     (slot_q[i]),
      .slot_nxt_o (slot_nxt[i])
    );
  end

  // sustained rise: five or more samples, no decreasing step anywhere in the window
  if (WINDOW >= 5) begin : g_sustain
    wire [WINDOW-2:0] brk_vec;
    for (genvar j = 0; j < WINDOW-1; j++) begin : g_brk
      assign brk_vec[j] = slot_nxt[j].brk;
    end
    assign sustained = slot_nxt[4].filled && !(|brk_vec);
  end else begin : g_no_sustain
    assign sustained = 1'b0;
  end

  // score in tens
  assign spread_x5 = {1'b0, smp.rtt_spread_us, 2'b00} + {3'b000, smp.rtt_spread_us};
  assign elapsed   = smp.now_us - sig_time_q;
  assign recent    = (status_q != ST_NONE) && seen_q && (elapsed < RECENT_US);

  always_comb begin
    tens = '0;
    case (smp.trend_code)
      TREND_INC:    tens = sustained ? 4'd8 : 4'd6;
      TREND_STABLE: tens = 4'd1;
      default:      tens = 4'd0;
    endcase
    if (smp.spike_seen) begin
      tens = tens + ((smp.trend_code == TREND_INC) ? 4'd4 : 4'd3);
    end
    if ((smp.rtt_mean_us != '0) && (spread_x5 > {3'b000, smp.rtt_mean_us})) begin
      tens = tens + 4'd1;
    end
  end

  // recent signal scales by 11/10, then clamp
  assign scaled = {4'b0000, tens} * (recent ? 8'd11 : 8'd10);
  assign score  = (scaled > {1'b0, PCT_MAX}) ? PCT_MAX : scaled[PCT_W-1:0];

  // status machine with hysteresis
  always_comb begin
    status_nxt = status_q;
    if (score > thresh_q) begin
      status_nxt = ST_IMMINENT;
    end else if ((smp.trend_code == TREND_INC) && (score > BUILDING_MIN)) begin
      status_nxt = ST_BUILDING;
    end else if ((smp.trend_code == TREND_DEC) || !seen_q ||
                 (elapsed > {{(TIME_W-RECOVERY_W){1'b0}}, recovery_q})) begin
      status_nxt = ST_NONE;
    end
  end

  always_comb begin
    prev_mean_d = prev_mean_q;
    status_d    = status_q;
    sig_time_d  = sig_time_q;
    seen_d      = seen_q;
    if (accept) begin
      prev_mean_d = smp.rtt_mean_us;
      status_d    = status_nxt;
      if ((status_nxt != ST_NONE) && (status_nxt != status_q)) begin
        sig_time_d = smp.now_us;
        seen_d     = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thresh_q    <= THRESHOLD_RST;
      recovery_q  <= RECOVERY_RST;
      prev_mean_q <= '0;
      status_q    <= ST_NONE;
      sig_time_q  <= '0;
      seen_q      <= 1'b0;
    end else begin
      thresh_q    <= thresh_d;
      recovery_q  <= recovery_d;
      prev_mean_q <= prev_mean_d;
      status_q    <= status_d;
      sig_time_q  <= sig_time_d;
      seen_q      <= seen_d;
    end
  end

  // result buffer
  assign result.congestion_status = status_nxt;
  assign result.confidence_pct    = score;

  rcd_out_buf u_out_buf (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (accept),
    .data_i  (result),
    .space_o (space),
    .valid_o (res_o.valid),
    .ready_i (res_o.ready),
    .data_o  (res_o.payload)
  );

  // checks
  `RCD_ASSERT_IMP(a_status_has_signal, clk_i, rst_ni, status_q != ST_NONE, seen_q)
  `RCD_ASSERT_IMP(a_pct_clamped, clk_i, rst_ni, res_o.valid, res_o.payload.confidence_pct <= PCT_MAX)
  `RCD_ASSERT_NXT(a_accept_gives_result, clk_i, rst_ni, accept, res_o.valid)
  `RCD_ASSERT_IMP(a_window_contig, clk_i, rst_ni, slot_q[WINDOW-1].filled, slot_q[0].filled)

endmodule

`default_nettype wire
